>>> rtl/core/iscc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iscc_pkg
// Shared types and constants of the insertion sorter with compare count.
// ----------------------------------------------------------------------------
package iscc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMP_W  = 12;
  localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the new value at its sorted slot
    logic shift;   // move every entry one cell toward the output
  } iscc_ctrl_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } iscc_state_e;

endpackage
`default_nettype wire

>>> rtl/core/iscc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iscc_cell
// One slot of the sorted chain: compares, takes its left neighbor's value on
// insert, takes its right neighbor's value on drain.
// ----------------------------------------------------------------------------
module iscc_cell (
  input  wire logic                        clk_i,
  input  wire iscc_pkg::iscc_ctrl_t        ctrl_i,
  input  wire logic [iscc_pkg::DATA_W-1:0] new_val_i,
  input  wire logic                        occ_i,
  input  wire logic                        prev_occ_i,
  input  wire logic                        prev_gt_i,
  input  wire logic [iscc_pkg::DATA_W-1:0] prev_val_i,
  input  wire logic [iscc_pkg::DATA_W-1:0] next_val_i,
  output logic      [iscc_pkg::DATA_W-1:0] val_o,
  output logic                             gt_o
);
  import iscc_pkg::*;

  logic [DATA_W-1:0] val_q, val_d;
  logic              take_new;

  // strict compare: equal values stay ahead of the newcomer
  assign gt_o = occ_i && ($signed(val_q) > $signed(new_val_i));

  // this cell changes on insert if it moves up or is the first free slot
  assign take_new = gt_o || (!occ_i && prev_occ_i);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = next_val_i;
    end else if (ctrl_i.insert && take_new) begin
      val_d = prev_gt_i ? prev_val_i : new_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

>>> rtl/core/iscc_pos_enc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iscc_pos_enc
// Converts the chain's not-greater thermometer into the insert position.
// ----------------------------------------------------------------------------
module iscc_pos_enc #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  wire logic [DEPTH-1:0] le_i,
  output logic      [CW-1:0]    pos_o
);

  logic [DEPTH-1:0] edge_hot;

  // le_i is a prefix of ones; its edge marks how many entries stay put
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) begin
        edge_hot[i] = le_i[i];
      end else begin
        edge_hot[i] = le_i[i] && !le_i[i+1];
      end
    end
  end

  always_comb begin
    pos_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_o = pos_o | ({CW{edge_hot[i]}} & CW'(i + 1));
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/insertion_sorter_with_compare_count.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sorter_with_compare_count
// Systolic insertion sorter of signed words with an insertion-sort
// comparison count, drained in ascending order on the last transfer.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                      tlast       tuser
//  s_axis   in   value[31:0]                             last        -
//  m_axis   out  sorted_value[31:0], compare_total[11:0] final_res   overflow
//
//  Fill: one input transfer per cycle; every cell compares against the new
//  value and shifts in the same cycle.
//  Drain: after a last transfer, one result per cycle for the n stored
//  values, each taken by a one-step shift of the chain; s_axis_tready
//  is low during drain, and m_axis_tready low holds the chain.
//  Reset: asynchronous active low; no clearing pass, the store is tracked
//  by its fill count.
// ----------------------------------------------------------------------------
module insertion_sorter_with_compare_count #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value[31:0]
  input  wire logic        s_axis_tlast,   // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // sorted_value[31:0], compare_total[43:32]
  output logic             m_axis_tlast,   // final_res
  output logic             m_axis_tuser    // overflow
);
  import iscc_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  iscc_state_e       state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CMP_W-1:0]  cmp_q, cmp_d;
  logic              ovf_q, ovf_d;

  iscc_ctrl_t        ctrl;
  logic              s_xfer, m_xfer, full;
  logic [CW-1:0]     pos, greater;
  logic [CMP_W:0]    cmp_sum;

  logic [DATA_W-1:0] cell_val  [DEPTH];
  logic [DATA_W-1:0] prev_val  [DEPTH];
  logic [DATA_W-1:0] next_val  [DEPTH];
  logic [DEPTH-1:0]  occ, prev_occ, gt, prev_gt, le;

  assign s_axis_tready = (state_q == ST_FILL);
  assign m_axis_tvalid = (state_q == ST_DRAIN);
  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;
  assign full   = (cnt_q == FULL_CNT);

  assign ctrl.insert = s_xfer && !full;
  assign ctrl.shift  = m_xfer;

  // neighbor wiring; cell 0 always sees an occupied, not-greater left side
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CW'(i) < cnt_q);
      if (i == 0) begin
        prev_occ[i] = 1'b1;
        prev_val[i] = s_axis_tdata;
      end else begin
        prev_occ[i] = occ[i-1];
        prev_val[i] = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin
        next_val[i] = '0;
      end else begin
        next_val[i] = cell_val[i+1];
      end
    end
  end

  // compare results coming back from the cells
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        prev_gt[i] = 1'b0;
      end else begin
        prev_gt[i] = gt[i-1];
      end
      le[i] = occ[i] && !gt[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    iscc_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_val_i  (s_axis_tdata),
      .occ_i      (occ[g]),
      .prev_occ_i (prev_occ[g]),
      .prev_gt_i  (prev_gt[g]),
      .prev_val_i (prev_val[g]),
      .next_val_i (next_val[g]),
      .val_o      (cell_val[g]),
      .gt_o       (gt[g])
    );
  end

  iscc_pos_enc #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_pos_enc (
    .le_i  (le),
    .pos_o (pos)
  );

  assign greater = cnt_q - pos;
  assign cmp_sum = {1'b0, cmp_q} + (CMP_W+1)'(greater) + (CMP_W+1)'(1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmp_d   = cmp_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_FILL: begin
        if (s_xfer) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + CW'(1);
            if (cnt_q != '0) begin
              cmp_d = cmp_sum[CMP_W] ? CMP_MAX : cmp_sum[CMP_W-1:0];
            end
          end
          if (s_axis_tlast) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (m_xfer) begin
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = ST_FILL;
            cmp_d   = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      cnt_q   <= '0;
      cmp_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cmp_q   <= cmp_d;
      ovf_q   <= ovf_d;
    end
  end

  assign m_axis_tdata = {4'b0000, cmp_q, cell_val[0]};
  assign m_axis_tlast = (cnt_q == CW'(1));
  assign m_axis_tuser = ovf_q;

endmodule
`default_nettype wire

>>> dv/sorted_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_stream_checker
// Watches both stream channels of the insertion sorter. It keeps its own
// sorted store and comparison count, queues the words that a closing transfer
// must drain, and checks every output transfer against the oldest of them.
// ----------------------------------------------------------------------------
module sorted_stream_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic        s_axis_tlast,   // last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // sorted_value[31:0], compare_total[43:32]
  input  logic        m_axis_tlast,   // final_res
  input  logic        m_axis_tuser,   // overflow
  output int          err_cnt_o,
  output int          pending_o
);
  import iscc_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     final_flag;
    logic [CMP_W-1:0]         total;
    logic                     ovf;
  } sorted_word_t;

  logic signed [DATA_W-1:0] held_vals [DEPTH];
  int                       held_cnt = 0;
  logic [CMP_W-1:0]         run_total = '0;
  logic                     dropped = 1'b0;
  sorted_word_t             drain_words [$];
  int                       fail_cnt = 0;

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX) $display("%t ERROR: %s", $realtime, msg);
  endfunction

  // Insert one value into the sorted store; a closing value drains the set.
  function automatic void absorb_value(logic signed [DATA_W-1:0] v, logic last);
    int           pos;
    int           greater;
    logic [CMP_W:0] sum;
    sorted_word_t w;
    if (held_cnt >= DEPTH) begin
      dropped = 1'b1;
    end else begin
      pos = held_cnt;
      greater = 0;
      // strict compare: equal values stay behind the ones already held
      while (pos > 0 && held_vals[pos-1] > v) begin
        held_vals[pos] = held_vals[pos-1];
        pos--;
        greater++;
      end
      held_vals[pos] = v;
      if (held_cnt > 0) begin
        sum = {1'b0, run_total} + (CMP_W+1)'(greater + 1);
        run_total = (sum > {1'b0, CMP_MAX}) ? CMP_MAX : sum[CMP_W-1:0];
      end
      held_cnt++;
    end
    if (last) begin
      for (int i = 0; i < held_cnt; i++) begin
        w.value      = held_vals[i];
        w.final_flag = (i == held_cnt - 1);
        w.total      = run_total;
        w.ovf        = dropped;
        drain_words.push_back(w);
      end
      held_cnt  = 0;
      run_total = '0;
      dropped   = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    sorted_word_t exp_w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (drain_words.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d total %0d final %0b ovf %0b",
                                 $signed(m_axis_tdata[31:0]), m_axis_tdata[43:32],
                                 m_axis_tlast, m_axis_tuser));
        end else begin
          exp_w = drain_words.pop_front();
          if (m_axis_tdata[31:0] !== exp_w.value || m_axis_tdata[43:32] !== exp_w.total ||
              m_axis_tlast !== exp_w.final_flag || m_axis_tuser !== exp_w.ovf) begin
            note_failure($sformatf({"mismatch (exp/act): value %0d/%0d total %0d/%0d ",
                                    "final %0b/%0b ovf %0b/%0b"},
                                   exp_w.value, $signed(m_axis_tdata[31:0]),
                                   exp_w.total, m_axis_tdata[43:32],
                                   exp_w.final_flag, m_axis_tlast,
                                   exp_w.ovf, m_axis_tuser));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_value(s_axis_tdata, s_axis_tlast);
      end
    end
    err_cnt_o <= fail_cnt;
    pending_o <= drain_words.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the insertion sorter: a few hand-picked sets
// (extremes, duplicates, single value, ascending and descending runs), then
// random sets including a full store and an overflowing one, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import iscc_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int          ITEMS_TOTAL = 270;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          TAIL_CYCLES = 50;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // value[31:0]
  logic        s_axis_tlast = 1'b0;  // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // sorted_value[31:0], compare_total[43:32]
  logic        m_axis_tlast;         // final_res
  logic        m_axis_tuser;         // overflow
  int          err_cnt;
  int          pending;
  int          items_sent = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  insertion_sorter_with_compare_count #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  sorted_stream_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending)
  );

  // Output side back-pressure: random stalls, mostly short, with calm stretches.
  int  stall_left = 0;
  int  sink_phase = 0;
  bit  sink_calm  = 1'b0;
  always @(posedge clk_i) begin
    int r;
    if (sink_phase == 0) begin
      sink_calm  = ($urandom_range(3) == 0);
      sink_phase = $urandom_range(200, 50);
    end else begin
      sink_phase--;
    end
    if (sink_calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if (r < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(2) : $urandom_range(40, 5);
        m_axis_tready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom;
    // narrow range gives plenty of duplicates
    if (r < 85) return 32'($signed($urandom_range(6)) - 3);
    case ($urandom_range(3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // valid stays high across back-to-back transfers; it drops only for a gap
  task automatic send_item(logic [31:0] v, logic last, bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] corner_vals [9];
    int          set_idx;
    int          len;
    bit          calm;
    corner_vals = '{VAL_MAX, VAL_MIN, 32'd0, 32'hffff_ffff, 32'd1, 32'd5, 32'd5,
                    32'hffff_fffb, 32'd5};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes and duplicates in one set
    foreach (corner_vals[i]) send_item(corner_vals[i], i == 8, 1'b0);
    // single value: count stays zero
    send_item(32'hffff_fff9, 1'b1, 1'b0);
    // descending: every pair inverted
    for (int i = 6; i >= 1; i--) send_item(32'(i), i == 1, 1'b0);
    // ascending: no inversions, back-to-back
    for (int i = 1; i <= 5; i++) send_item(32'(i), i == 5, 1'b1);
    send_item(VAL_MAX, 1'b0, 1'b0);
    send_item(VAL_MIN, 1'b1, 1'b0);

    set_idx = 0;
    while (items_sent < ITEMS_TOTAL) begin
      if (set_idx == 2)
        len = DEPTH;                // fills the store exactly
      else if (set_idx == 5)
        len = DEPTH + 3;            // overflow, the closing value dropped too
      else if ($urandom_range(4) != 0)
        len = $urandom_range(12, 1);
      else
        len = $urandom_range(40, 13);
      calm = ($urandom_range(3) == 0);
      for (int i = 0; i < len; i++) send_item(pick_value(), i == len - 1, calm);
      set_idx++;
    end
    s_axis_tvalid <= 1'b0;

    // the checker's pending count is a registered copy of its queue size
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> insertion_sorter_with_compare_count.f
rtl/core/iscc_pkg.sv
rtl/core/iscc_cell.sv
rtl/core/iscc_pos_enc.sv
rtl/core/insertion_sorter_with_compare_count.sv
dv/sorted_stream_checker.sv
dv/tb.sv
